@@ design/spe_pkg.sv @@
// ----------------------------------------------------------------------------
// spe_pkg
// shared constants, types and helpers of the section palette encoder
// ----------------------------------------------------------------------------
package spe_pkg;

  localparam int BLOCK_ID_W   = 16;
  localparam int ID_BITS      = 16;
  localparam int ID_COUNT     = 1 << ID_BITS;
  localparam int SECTION_SIZE = 4096;
  localparam int IDX_W        = $clog2(SECTION_SIZE);
  localparam int CNT_W        = IDX_W + 1;
  localparam int PAL_IDX_W    = 12;
  localparam int BPE_W        = 4;
  localparam int MIN_BITS     = 4;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // map update issued by the resolve stage
  typedef struct packed {
    logic en;
    id_t  id;
    idx_t idx;
  } map_wr_t;

  // word leaving the lookup pipeline, with its resolved mapping
  typedef struct packed {
    logic valid;
    id_t  id;
    logic last;
    logic hit;
    idx_t idx;
  } look_t;

  // ceil(log2(size)) with a floor, empty palette gives the floor
  function automatic logic [BPE_W-1:0] entry_bits(cnt_t size);
    logic [IDX_W-1:0] below;
    logic [BPE_W-1:0] r;
    for (int k = 0; k < IDX_W; k++) begin
      below[k] = (cnt_t'(1) << k) < size;
    end
    r = BPE_W'($countones(below));
    if (size == '0 || r < BPE_W'(MIN_BITS)) begin
      r = BPE_W'(MIN_BITS);
    end
    return r;
  endfunction

endpackage

@@ design/spe_in_if.sv @@
// ----------------------------------------------------------------------------
// spe_in_if
// input channel: one block identifier word per handshake
// ----------------------------------------------------------------------------
interface spe_in_if;
  logic                           valid;
  logic                           ready;
  logic [spe_pkg::BLOCK_ID_W-1:0] block_id;
  logic                           section_last;

  modport source (output valid, output block_id, output section_last, input ready);
  modport sink   (input valid, input block_id, input section_last, output ready);
endinterface

@@ design/spe_out_if.sv @@
// ----------------------------------------------------------------------------
// spe_out_if
// output channel: palette index and section summary word
// ----------------------------------------------------------------------------
interface spe_out_if;
  logic                          valid;
  logic                          ready;
  logic [spe_pkg::PAL_IDX_W-1:0] palette_index;
  logic                          is_new;
  logic                          section_done;
  logic [spe_pkg::CNT_W-1:0]     palette_size;
  logic [spe_pkg::BPE_W-1:0]     bits_per_entry;
  logic [spe_pkg::CNT_W-1:0]     non_air_count;

  modport source (output valid, output palette_index, output is_new, output section_done,
                  output palette_size, output bits_per_entry, output non_air_count,
                  input ready);
  modport sink   (input valid, input palette_index, input is_new, input section_done,
                  input palette_size, input bits_per_entry, input non_air_count,
                  output ready);
endinterface

@@ design/spe_lookup.sv @@
// ----------------------------------------------------------------------------
// spe_lookup
// two-stage map lookup: id to index, then index back to id, with forwarding
// ----------------------------------------------------------------------------
module spe_lookup (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              in_valid_i,
  input  spe_pkg::id_t      in_id_i,
  input  logic              in_last_i,
  input  spe_pkg::cnt_t     next_index_i,
  input  spe_pkg::map_wr_t  wr_i,
  output spe_pkg::look_t    s2_o
);

  // id to palette index, and palette index back to id
  spe_pkg::idx_t idx_mem [spe_pkg::ID_COUNT];
  spe_pkg::id_t  id_mem  [spe_pkg::SECTION_SIZE];

  spe_pkg::idx_t a_q;
  spe_pkg::id_t  b_q;

  logic          s1_valid_q, s2_valid_q;
  spe_pkg::id_t  s1_id_q, s2_id_q;
  logic          s1_last_q, s2_last_q;
  spe_pkg::idx_t s2_a_q;

  // the two most recent map updates, not yet visible to reads in flight
  logic          h1_ent_q, h2_ent_q;
  spe_pkg::id_t  h1_id_q, h2_id_q;
  spe_pkg::idx_t h1_idx_q, h2_idx_q;

  spe_pkg::id_t  b_fwd;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      idx_mem[wr_i.id] <= wr_i.idx;
    end
    if (adv_i) begin
      a_q <= idx_mem[in_id_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      id_mem[wr_i.idx] <= wr_i.id;
    end
    if (adv_i) begin
      b_q <= id_mem[a_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      h1_ent_q   <= 1'b0;
      h2_ent_q   <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      // a section end retires every pending update
      h1_ent_q   <= wr_i.en && !s2_last_q;
      h2_ent_q   <= h1_ent_q && !(s2_valid_q && s2_last_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_id_q   <= in_id_i;
      s1_last_q <= in_last_i;
      s2_id_q   <= s1_id_q;
      s2_last_q <= s1_last_q;
      s2_a_q    <= a_q;
      h1_id_q   <= wr_i.id;
      h1_idx_q  <= wr_i.idx;
      h2_id_q   <= h1_id_q;
      h2_idx_q  <= h1_idx_q;
    end
  end

  always_comb begin
    b_fwd       = (h1_ent_q && h1_idx_q == s2_a_q) ? h1_id_q : b_q;
    s2_o.valid  = s2_valid_q;
    s2_o.id     = s2_id_q;
    s2_o.last   = s2_last_q;
    if (h1_ent_q && h1_id_q == s2_id_q) begin
      s2_o.hit = 1'b1;
      s2_o.idx = h1_idx_q;
    end else if (h2_ent_q && h2_id_q == s2_id_q) begin
      s2_o.hit = 1'b1;
      s2_o.idx = h2_idx_q;
    end else begin
      // entries below the fill mark were written in this section
      s2_o.hit = (spe_pkg::cnt_t'(s2_a_q) < next_index_i) && (b_fwd == s2_id_q);
      s2_o.idx = s2_a_q;
    end
  end

endmodule

@@ design/section_palette_encoder.sv @@
// ----------------------------------------------------------------------------
// section_palette_encoder: input word passes lookup stages s1 and s2, then the output register
// throughput one word per cycle while the output is not stalled, set by one read-modify-write of the maps
// async reset clears pipeline valids and counters, no memory clearing pass
// ----------------------------------------------------------------------------
module section_palette_encoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  spe_in_if.sink    in_i,
  spe_out_if.source out_o
);

  // pipeline moves whenever the output register is free or being drained
  logic             adv;
  spe_pkg::look_t   s2;
  spe_pkg::map_wr_t wr;

  // section state: fill mark of the palette and non-air count
  spe_pkg::cnt_t next_index_q, next_index_d;
  spe_pkg::cnt_t non_air_q, non_air_d;

  logic          entered;
  spe_pkg::cnt_t next_cnt;
  spe_pkg::cnt_t non_air_cnt;
  spe_pkg::idx_t res_idx;

  // output register
  logic                          out_valid_q;
  logic [spe_pkg::PAL_IDX_W-1:0] out_index_q;
  logic                          out_new_q;
  logic                          out_done_q;
  spe_pkg::cnt_t                 out_size_q;
  logic [spe_pkg::BPE_W-1:0]     out_bpe_q;
  spe_pkg::cnt_t                 out_nat_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  spe_lookup u_lookup (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .in_valid_i   (in_i.valid),
    .in_id_i      (in_i.block_id[spe_pkg::ID_BITS-1:0]),
    .in_last_i    (in_i.section_last),
    .next_index_i (next_index_q),
    .wr_i         (wr),
    .s2_o         (s2)
  );

  always_comb begin
    // a fresh id enters only while the palette has room
    entered     = s2.valid && !s2.hit &&
                  (next_index_q < spe_pkg::cnt_t'(spe_pkg::SECTION_SIZE));
    next_cnt    = next_index_q + spe_pkg::cnt_t'(entered);
    non_air_cnt = non_air_q;
    if (s2.id != '0 && non_air_q < spe_pkg::cnt_t'(spe_pkg::SECTION_SIZE)) begin
      non_air_cnt = non_air_q + spe_pkg::cnt_t'(1);
    end

    // known id keeps its index, a full palette answers zero
    if (s2.hit) begin
      res_idx = s2.idx;
    end else if (entered) begin
      res_idx = next_index_q[spe_pkg::IDX_W-1:0];
    end else begin
      res_idx = '0;
    end

    wr.en  = adv && entered;
    wr.id  = s2.id;
    wr.idx = next_index_q[spe_pkg::IDX_W-1:0];

    // last word of a section resets the counters for the next one
    next_index_d = next_index_q;
    non_air_d    = non_air_q;
    if (adv && s2.valid) begin
      next_index_d = s2.last ? '0 : next_cnt;
      non_air_d    = s2.last ? '0 : non_air_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_index_q <= '0;
      non_air_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      next_index_q <= next_index_d;
      non_air_q    <= non_air_d;
      if (adv) begin
        out_valid_q <= s2.valid;
      end
    end
  end

  // result payload, summary fields only on the section's last word
  always_ff @(posedge clk_i) begin
    if (adv && s2.valid) begin
      out_index_q <= spe_pkg::PAL_IDX_W'(res_idx);
      out_new_q   <= entered;
      out_done_q  <= s2.last;
      out_size_q  <= s2.last ? next_cnt : '0;
      out_bpe_q   <= s2.last ? spe_pkg::entry_bits(next_cnt) : '0;
      out_nat_q   <= s2.last ? non_air_cnt : '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.palette_index  = out_index_q;
  assign out_o.is_new         = out_new_q;
  assign out_o.section_done   = out_done_q;
  assign out_o.palette_size   = out_size_q;
  assign out_o.bits_per_entry = out_bpe_q;
  assign out_o.non_air_count  = out_nat_q;

`ifndef ASSERT_OFF
  // fill mark never passes the palette capacity
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_index_q <= spe_pkg::cnt_t'(spe_pkg::SECTION_SIZE))
    else $error("palette fill mark beyond capacity");

  // non-air count saturates at the section size
  a_nat_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    non_air_q <= spe_pkg::cnt_t'(spe_pkg::SECTION_SIZE))
    else $error("non-air count beyond section size");

  // a section's last word leaves both counters cleared
  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2.valid && s2.last) |=> (next_index_q == '0 && non_air_q == '0))
    else $error("section state not cleared after last word");

  // a fresh entry that is not a section's last word advances the fill mark by one
  a_fill_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.en && !s2.last) |=> (next_index_q == $past(next_index_q) + spe_pkg::cnt_t'(1)))
    else $error("fill mark did not follow a fresh entry");

  // summary width stays within its legal span
  a_bpe_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.section_done) |->
      (out_o.bits_per_entry >= 4'd4 && out_o.bits_per_entry <= 4'd12))
    else $error("bits per entry out of range");
`endif

endmodule
